// ===== rtl/core/mhs_pkg.sv =====
`default_nettype none

package mhs_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_KMER_D   = 32;
    localparam int MAX_SKETCH_D = 64;
    localparam int MAX_SLOTS_D  = 256;

    // Hash constants
    localparam logic [63:0] HASH_SEED = 64'd314159265;
    localparam logic [63:0] MM_C1     = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2     = 64'h4cf5ad432745937f;
    localparam logic [63:0] FM_C1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FM_C2     = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] H1_ADD    = 64'h0000000052dce729;
    localparam logic [63:0] H2_ADD    = 64'h0000000038495ab5;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_H_INIT,
        OP_H_LOAD,
        OP_MUL,
        OP_ROT_K1,
        OP_ROT_K2,
        OP_H1_A,
        OP_H1_B,
        OP_H2_A,
        OP_H2_B,
        OP_XOR_K,
        OP_LEN,
        OP_ADD21,
        OP_SHX,
        OP_FIN,
        OP_I_START,
        OP_I_NEXT,
        OP_I_SPLIT,
        OP_I_SHIFT,
        OP_I_APPEND,
        OP_C_START,
        OP_C_WR,
        OP_Q_INIT,
        OP_Q_LOAD,
        OP_Q_STEP,
        OP_Q_CMP,
        OP_RES
    } t_op;

    // Multiplier operand register and constant
    typedef enum logic [1:0] {MS_K1, MS_K2, MS_H1, MS_H2} t_msel;
    typedef enum logic [1:0] {CS_C1, CS_C2, CS_F1, CS_F2} t_csel;

    typedef struct packed {
        t_op        op;
        t_msel      msel;
        t_csel      csel;
        logic [1:0] ph;
    } t_cmd;

    typedef struct packed {
        logic win_full;
        logic blk_left;
        logic at_end;
        logic room;
        logic shifting;
        logic lt;
        logic eq;
        logic full;
        logic slots_done;
        logic m_end;
        logic out_busy;
        logic kind;
        logic last;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/mhs_if.sv =====
`default_nettype none

interface mhs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] base;
    logic       last;

    modport source(output valid, kind, base, last, input ready);
    modport sink(input valid, kind, base, last, output ready);
endinterface

interface mhs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] slot_or_best;
    logic       found;
    logic [6:0] hits;
    logic [6:0] query_size;
    logic [6:0] stored_size;

    modport source(output valid, slot_or_best, found, hits, query_size, stored_size,
                   input ready);
    modport sink(input valid, slot_or_best, found, hits, query_size, stored_size,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mhs_ctrl.sv =====
`default_nettype none

module mhs_ctrl
    import mhs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_HINIT, S_HLOAD, S_HBLK, S_HTAIL, S_IST, S_IRD, S_IEV,
        S_END, S_CRD, S_CWR, S_QSZ, S_QLD, S_QRD, S_QEV, S_QCMP, S_RES
    } t_state;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        t_csel csel;
        logic  fin;
    } t_ustep;

    t_state     r_state, n_state;
    logic [4:0] r_upc, n_upc;
    logic [1:0] r_ph, n_ph;
    t_ustep     us;

    function automatic t_ustep mk(input t_op op, input t_msel ms, input t_csel cs,
                                  input logic fin);
        t_ustep s;
        s.op   = op;
        s.msel = ms;
        s.csel = cs;
        s.fin  = fin;
        return s;
    endfunction

    // Mixing of one full 16-byte block
    function automatic t_ustep blk_step(input logic [4:0] upc);
        t_ustep s;
        case (upc)
            5'd0:    s = mk(OP_MUL, MS_K1, CS_C1, 1'b0);
            5'd1:    s = mk(OP_ROT_K1, MS_K1, CS_C1, 1'b0);
            5'd2:    s = mk(OP_MUL, MS_K1, CS_C2, 1'b0);
            5'd3:    s = mk(OP_H1_A, MS_K1, CS_C1, 1'b0);
            5'd4:    s = mk(OP_H1_B, MS_K1, CS_C1, 1'b0);
            5'd5:    s = mk(OP_MUL, MS_K2, CS_C2, 1'b0);
            5'd6:    s = mk(OP_ROT_K2, MS_K2, CS_C1, 1'b0);
            5'd7:    s = mk(OP_MUL, MS_K2, CS_C1, 1'b0);
            5'd8:    s = mk(OP_H2_A, MS_K2, CS_C1, 1'b0);
            default: s = mk(OP_H2_B, MS_K2, CS_C1, 1'b1);
        endcase
        return s;
    endfunction

    // Tail bytes, length fold and final avalanche
    function automatic t_ustep tail_step(input logic [4:0] upc);
        t_ustep s;
        case (upc)
            5'd0:    s = mk(OP_MUL, MS_K2, CS_C2, 1'b0);
            5'd1:    s = mk(OP_ROT_K2, MS_K2, CS_C1, 1'b0);
            5'd2:    s = mk(OP_MUL, MS_K2, CS_C1, 1'b0);
            5'd3:    s = mk(OP_MUL, MS_K1, CS_C1, 1'b0);
            5'd4:    s = mk(OP_ROT_K1, MS_K1, CS_C1, 1'b0);
            5'd5:    s = mk(OP_MUL, MS_K1, CS_C2, 1'b0);
            5'd6:    s = mk(OP_XOR_K, MS_K1, CS_C1, 1'b0);
            5'd7:    s = mk(OP_LEN, MS_K1, CS_C1, 1'b0);
            5'd8:    s = mk(OP_ADD21, MS_K1, CS_C1, 1'b0);
            5'd9:    s = mk(OP_SHX, MS_K1, CS_C1, 1'b0);
            5'd10:   s = mk(OP_MUL, MS_H1, CS_F1, 1'b0);
            5'd11:   s = mk(OP_MUL, MS_H2, CS_F1, 1'b0);
            5'd12:   s = mk(OP_SHX, MS_K1, CS_C1, 1'b0);
            5'd13:   s = mk(OP_MUL, MS_H1, CS_F2, 1'b0);
            5'd14:   s = mk(OP_MUL, MS_H2, CS_F2, 1'b0);
            5'd15:   s = mk(OP_SHX, MS_K1, CS_C1, 1'b0);
            default: s = mk(OP_FIN, MS_K1, CS_C1, 1'b1);
        endcase
        return s;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command
    always_comb begin
        n_state     = r_state;
        n_upc       = r_upc;
        n_ph        = r_ph;
        us          = (r_state == S_HBLK) ? blk_step(r_upc) : tail_step(r_upc);
        o_cmd.op    = OP_NONE;
        o_cmd.msel  = MS_K1;
        o_cmd.csel  = CS_C1;
        o_cmd.ph    = r_ph;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_stat.win_full ? S_HINIT : S_END;
            end
            S_HINIT: begin
                o_cmd.op = OP_H_INIT;
                n_state  = S_HLOAD;
            end
            S_HLOAD: begin
                o_cmd.op = OP_H_LOAD;
                n_state  = i_stat.blk_left ? S_HBLK : S_HTAIL;
            end
            S_HBLK, S_HTAIL: begin
                o_cmd.op   = us.op;
                o_cmd.msel = us.msel;
                o_cmd.csel = us.csel;
                if (us.op == OP_MUL && r_ph != 2'd3) begin
                    n_ph = r_ph + 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (us.fin) begin
                        n_upc   = 5'd0;
                        n_state = (r_state == S_HBLK) ? S_HLOAD : S_IST;
                    end else begin
                        n_upc = r_upc + 5'd1;
                    end
                end
            end
            S_IST: begin
                o_cmd.op = OP_I_START;
                n_state  = S_IRD;
            end
            S_IRD: begin
                if (i_stat.at_end) begin
                    if (i_stat.room) begin
                        o_cmd.op = OP_I_APPEND;
                    end
                    n_state = S_END;
                end else begin
                    n_state = S_IEV;
                end
            end
            S_IEV: begin
                n_state = S_IRD;
                if (i_stat.shifting) begin
                    o_cmd.op = OP_I_SHIFT;
                end else if (i_stat.lt) begin
                    o_cmd.op = OP_I_NEXT;
                end else if (i_stat.eq) begin
                    n_state = S_END;
                end else begin
                    o_cmd.op = OP_I_SPLIT;
                end
            end
            S_END: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_stat.kind) begin
                    o_cmd.op = OP_Q_INIT;
                    n_state  = S_QSZ;
                end else if (i_stat.full) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.op = OP_C_START;
                    n_state  = S_CRD;
                end
            end
            S_CRD: begin
                n_state = i_stat.at_end ? S_RES : S_CWR;
            end
            S_CWR: begin
                o_cmd.op = OP_C_WR;
                n_state  = S_CRD;
            end
            S_QSZ: begin
                n_state = i_stat.slots_done ? S_RES : S_QLD;
            end
            S_QLD: begin
                o_cmd.op = OP_Q_LOAD;
                n_state  = S_QRD;
            end
            S_QRD: begin
                n_state = i_stat.m_end ? S_QCMP : S_QEV;
            end
            S_QEV: begin
                o_cmd.op = OP_Q_STEP;
                n_state  = S_QRD;
            end
            S_QCMP: begin
                o_cmd.op = OP_Q_CMP;
                n_state  = S_QSZ;
            end
            S_RES: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_RES;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and program counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_upc   <= 5'd0;
            r_ph    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_ph    <= n_ph;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mhs_dp.sv =====
`default_nettype none

module mhs_dp
    import mhs_pkg::*;
#(
    parameter  int MAX_KMER   = MAX_KMER_D,
    parameter  int MAX_SKETCH = MAX_SKETCH_D,
    parameter  int MAX_SLOTS  = MAX_SLOTS_D,
    localparam int KLEN_W     = $clog2(MAX_KMER + 1),
    localparam int CNT_W      = $clog2(MAX_SKETCH + 1)
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [KLEN_W-1:0] i_klen,
    input  wire logic [CNT_W-1:0]  i_jlen,
    input  wire logic              i_kind,
    input  wire logic [7:0]        i_base,
    input  wire logic              i_last,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_slot_or_best,
    output logic                   o_found,
    output logic [6:0]             o_hits,
    output logic [6:0]             o_query_size,
    output logic [6:0]             o_stored_size
);

    localparam int IDX_W  = (MAX_SKETCH > 1) ? $clog2(MAX_SKETCH) : 1;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCNT_W = $clog2(MAX_SLOTS + 1);
    localparam int SDEPTH = MAX_SLOTS * MAX_SKETCH;
    localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int WIN_W  = 8 * MAX_KMER;
    localparam int BUF_W  = (MAX_KMER / 16 + 1) * 128;
    localparam int DEN_W  = CNT_W + 1;
    localparam int PRD_W  = CNT_W + DEN_W;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // Window and hash state
    logic [WIN_W-1:0]  r_win;
    logic [KLEN_W-1:0] r_seen;
    logic              r_kind, r_last;
    logic [BUF_W-1:0]  r_buf;
    logic [KLEN_W-1:0] r_blk;
    logic [63:0]       r_h1, r_h2, r_k1, r_k2, r_acc, r_prod;
    logic [31:0]       r_hash;

    // Sketch memories
    logic [31:0]       r_cur [MAX_SKETCH];
    logic [31:0]       r_rd;
    logic [31:0]       r_store [SDEPTH];
    logic [31:0]       r_srd;
    logic [CNT_W-1:0]  r_sizes [MAX_SLOTS];
    logic [CNT_W-1:0]  r_zrd;

    // Insertion, copy and match state
    logic [CNT_W-1:0]  r_cnt, r_a, r_b, r_h, r_nb, r_bh, r_bnb;
    logic              r_shift;
    logic [31:0]       r_carry;
    logic [SCNT_W-1:0] r_nstored, r_s;
    logic [DEN_W-1:0]  r_bden;
    logic [SLOT_W-1:0] r_bslot;
    logic              r_bfound;

    // Result register
    logic              r_ovalid;
    logic [7:0]        r_oslot;
    logic              r_ofound;
    logic [6:0]        r_ohits, r_oqs, r_oss;

    logic [63:0]       mop, mcon, prod, mres;
    logic [31:0]       ma, mb;
    logic              full;
    logic [DEN_W-1:0]  den;
    logic              better;
    logic [SA_W-1:0]   st_waddr, st_raddr;
    logic              cur_we;
    logic [31:0]       cur_wd;

    // Select multiplier operand and constant
    always_comb begin
        case (i_cmd.msel)
            MS_K1:   mop = r_k1;
            MS_K2:   mop = r_k2;
            MS_H1:   mop = r_h1;
            default: mop = r_h2;
        endcase
        case (i_cmd.csel)
            CS_C1:   mcon = MM_C1;
            CS_C2:   mcon = MM_C2;
            CS_F1:   mcon = FM_C1;
            default: mcon = FM_C2;
        endcase
        case (i_cmd.ph)
            2'd0:    begin ma = mop[31:0];  mb = mcon[31:0];  end
            2'd1:    begin ma = mop[31:0];  mb = mcon[63:32]; end
            default: begin ma = mop[63:32]; mb = mcon[31:0];  end
        endcase
        prod = 64'(ma) * 64'(mb);
        mres = r_acc + {r_prod[31:0], 32'h0};
    end

    assign full     = (r_nstored == SCNT_W'(MAX_SLOTS));
    assign den      = DEN_W'(r_cnt) + DEN_W'(r_nb) - DEN_W'(r_h);
    assign better   = (PRD_W'(r_h) * PRD_W'(r_bden)) > (PRD_W'(r_bh) * PRD_W'(den));
    assign st_waddr = SA_W'(r_nstored[SLOT_W-1:0]) * SA_W'(MAX_SKETCH)
                      + SA_W'(r_a[IDX_W-1:0]);
    assign st_raddr = SA_W'(r_s[SLOT_W-1:0]) * SA_W'(MAX_SKETCH)
                      + SA_W'(r_b[IDX_W-1:0]);

    // Write port of the current sketch
    always_comb begin
        cur_we = 1'b0;
        cur_wd = r_hash;
        case (i_cmd.op)
            OP_I_SPLIT:  begin cur_we = 1'b1; cur_wd = r_hash; end
            OP_I_SHIFT:  begin cur_we = 1'b1; cur_wd = r_carry; end
            OP_I_APPEND: begin cur_we = 1'b1; cur_wd = r_shift ? r_carry : r_hash; end
            default:     cur_we = 1'b0;
        endcase
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            r_cur[r_a[IDX_W-1:0]] <= cur_wd;
        end
        if (i_cmd.op == OP_C_WR) begin
            r_store[st_waddr] <= r_rd;
        end
        if (i_cmd.op == OP_RES && !r_kind && !full) begin
            r_sizes[r_nstored[SLOT_W-1:0]] <= r_cnt;
        end
        r_rd  <= r_cur[r_a[IDX_W-1:0]];
        r_srd <= r_store[st_raddr];
        r_zrd <= r_sizes[r_s[SLOT_W-1:0]];
    end

    // Control counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_cnt     <= '0;
            r_nstored <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_RES) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_TAKE: begin
                    if (r_seen != KLEN_W'(MAX_KMER)) begin
                        r_seen <= r_seen + 1'b1;
                    end
                    if (r_cnt > i_jlen) begin
                        r_cnt <= i_jlen;
                    end
                end
                OP_I_APPEND: r_cnt <= r_cnt + 1'b1;
                OP_RES: begin
                    r_seen   <= '0;
                    r_cnt    <= '0;
                    if (!r_kind && !full) begin
                        r_nstored <= r_nstored + 1'b1;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_TAKE: begin
                r_win  <= (r_win >> 8) | (WIN_W'(i_base) << (WIN_W - 8));
                r_kind <= i_kind;
                r_last <= i_last;
            end
            OP_H_INIT: begin
                r_h1  <= HASH_SEED;
                r_h2  <= HASH_SEED;
                r_buf <= BUF_W'(r_win) >> {(KLEN_W'(MAX_KMER) - i_klen), 3'b000};
                r_blk <= i_klen >> 4;
            end
            OP_H_LOAD: begin
                r_k1  <= r_buf[63:0];
                r_k2  <= r_buf[127:64];
                r_buf <= r_buf >> 128;
                if (r_blk != '0) begin
                    r_blk <= r_blk - 1'b1;
                end
            end
            OP_MUL: begin
                // Low 64 bits of the product from three partial products
                case (i_cmd.ph)
                    2'd0: r_prod <= prod;
                    2'd1: begin
                        r_acc  <= r_prod;
                        r_prod <= prod;
                    end
                    2'd2: begin
                        r_acc  <= mres;
                        r_prod <= prod;
                    end
                    default: begin
                        case (i_cmd.msel)
                            MS_K1:   r_k1 <= mres;
                            MS_K2:   r_k2 <= mres;
                            MS_H1:   r_h1 <= mres;
                            default: r_h2 <= mres;
                        endcase
                    end
                endcase
            end
            OP_ROT_K1: r_k1 <= rotl64(r_k1, 31);
            OP_ROT_K2: r_k2 <= rotl64(r_k2, 33);
            OP_H1_A:   r_h1 <= rotl64(r_h1 ^ r_k1, 27) + r_h2;
            OP_H1_B:   r_h1 <= (r_h1 << 2) + r_h1 + H1_ADD;
            OP_H2_A:   r_h2 <= rotl64(r_h2 ^ r_k2, 31) + r_h1;
            OP_H2_B:   r_h2 <= (r_h2 << 2) + r_h2 + H2_ADD;
            OP_XOR_K: begin
                r_h1 <= r_h1 ^ r_k1;
                r_h2 <= r_h2 ^ r_k2;
            end
            OP_LEN: begin
                r_h1 <= (r_h1 ^ 64'(i_klen)) + (r_h2 ^ 64'(i_klen));
                r_h2 <= r_h2 ^ 64'(i_klen);
            end
            OP_ADD21:  r_h2 <= r_h2 + r_h1;
            OP_SHX: begin
                r_h1 <= r_h1 ^ (r_h1 >> 33);
                r_h2 <= r_h2 ^ (r_h2 >> 33);
            end
            OP_FIN:    r_hash <= r_h1[31:0] + r_h2[31:0];
            OP_I_START: begin
                r_a     <= '0;
                r_shift <= 1'b0;
            end
            OP_I_NEXT: r_a <= r_a + 1'b1;
            OP_I_SPLIT: begin
                r_carry <= r_rd;
                r_shift <= 1'b1;
                r_a     <= r_a + 1'b1;
            end
            OP_I_SHIFT: begin
                r_carry <= r_rd;
                r_a     <= r_a + 1'b1;
            end
            OP_C_START: r_a <= '0;
            OP_C_WR:    r_a <= r_a + 1'b1;
            OP_Q_INIT: begin
                r_s      <= '0;
                r_bfound <= 1'b0;
                r_bh     <= '0;
                r_bden   <= '0;
                r_bslot  <= '0;
                r_bnb    <= '0;
            end
            OP_Q_LOAD: begin
                r_nb <= r_zrd;
                r_a  <= '0;
                r_b  <= '0;
                r_h  <= '0;
            end
            OP_Q_STEP: begin
                // Advance the merge of two sorted lists
                if (r_rd == r_srd) begin
                    r_h <= r_h + 1'b1;
                    r_a <= r_a + 1'b1;
                    r_b <= r_b + 1'b1;
                end else if (r_rd < r_srd) begin
                    r_a <= r_a + 1'b1;
                end else begin
                    r_b <= r_b + 1'b1;
                end
            end
            OP_Q_CMP: begin
                // Keep the first slot with the strictly greatest ratio
                if (den != '0 && (!r_bfound || better)) begin
                    r_bfound <= 1'b1;
                    r_bh     <= r_h;
                    r_bden   <= den;
                    r_bslot  <= r_s[SLOT_W-1:0];
                    r_bnb    <= r_nb;
                end
                r_s <= r_s + 1'b1;
            end
            OP_RES: begin
                r_oqs <= 7'(r_cnt);
                if (r_kind) begin
                    r_oslot  <= 8'(r_bslot);
                    r_ofound <= r_bfound;
                    r_ohits  <= 7'(r_bh);
                    r_oss    <= 7'(r_bnb);
                end else begin
                    r_oslot  <= full ? 8'd0 : 8'(r_nstored);
                    r_ofound <= !full;
                    r_ohits  <= 7'd0;
                    r_oss    <= full ? 7'd0 : 7'(r_cnt);
                end
            end
            default: r_hash <= r_hash;
        endcase
    end

    // Status to the controller
    always_comb begin
        o_stat.win_full   = (r_seen >= i_klen);
        o_stat.blk_left   = (r_blk != '0);
        o_stat.at_end     = (r_a == r_cnt);
        o_stat.room       = (r_cnt < i_jlen);
        o_stat.shifting   = r_shift;
        o_stat.lt         = (r_rd < r_hash);
        o_stat.eq         = (r_rd == r_hash);
        o_stat.full       = full;
        o_stat.slots_done = (r_s == r_nstored);
        o_stat.m_end      = (r_a >= r_cnt) || (r_b >= r_nb);
        o_stat.out_busy   = r_ovalid && !i_out_ready;
        o_stat.kind       = r_kind;
        o_stat.last       = r_last;
    end

    assign o_out_valid    = r_ovalid;
    assign o_slot_or_best = r_oslot;
    assign o_found        = r_ofound;
    assign o_hits         = r_ohits;
    assign o_query_size   = r_oqs;
    assign o_stored_size  = r_oss;

endmodule

`default_nettype wire

// ===== rtl/core/minhash_sketch_store_and_match_top.sv =====
`default_nettype none

// MinHash sketch store and match. Bytes come in one transaction at a time; every full
// window of kmer_length bytes is hashed (MurmurHash3 x64_128, low 32 bits) and the
// sketch_size smallest distinct hashes are kept sorted. A final add byte stores the
// sketch in the next slot unless all slots are full; a final query byte returns the
// first slot with the greatest Jaccard ratio. One byte at a time is in work. Once the
// window is full, it is hashed on one shared 32x32 multiplier, and the hash is then
// inserted in sorted order through the single-port sketch memory. The end of a record
// adds the result step, and for a stored add a copy of the sketch entries, or for a
// query, per stored slot, a merge of the two sorted lists (at most query size plus
// stored size steps). The result sits in an output register, so the next byte is taken
// while it waits; a record end stalls only while an earlier result is still waiting.
module minhash_sketch_store_and_match_top
    import mhs_pkg::*;
#(
    parameter int MAX_KMER   = MAX_KMER_D,
    parameter int MAX_SKETCH = MAX_SKETCH_D,
    parameter int MAX_SLOTS  = MAX_SLOTS_D
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mhs_in_if.sink           i_in,
    mhs_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int KLEN_W = $clog2(MAX_KMER + 1);
    localparam int CNT_W  = $clog2(MAX_SKETCH + 1);
    localparam logic REG_KMER   = 1'b0;
    localparam logic REG_SKETCH = 1'b1;

    logic [5:0]        r_kmer;
    logic [6:0]        r_sketch;
    logic [KLEN_W-1:0] klen;
    logic [CNT_W-1:0]  jlen;
    t_cmd              cmd;
    t_stat             stat;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer   <= 6'd21;
            r_sketch <= 7'd32;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_KMER:   r_kmer   <= pwdata[5:0];
                REG_SKETCH: r_sketch <= pwdata[6:0];
                default:    r_kmer   <= r_kmer;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_KMER:   prdata = 32'(r_kmer);
            REG_SKETCH: prdata = 32'(r_sketch);
            default:    prdata = 32'd0;
        endcase
    end

    // Clamp the registers to the supported ranges
    always_comb begin
        if (r_kmer == 6'd0) begin
            klen = KLEN_W'(1);
        end else if (int'(r_kmer) > MAX_KMER) begin
            klen = KLEN_W'(MAX_KMER);
        end else begin
            klen = KLEN_W'(r_kmer);
        end
        if (r_sketch == 7'd0) begin
            jlen = CNT_W'(1);
        end else if (int'(r_sketch) > MAX_SKETCH) begin
            jlen = CNT_W'(MAX_SKETCH);
        end else begin
            jlen = CNT_W'(r_sketch);
        end
    end

    mhs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mhs_dp #(
        .MAX_KMER   (MAX_KMER),
        .MAX_SKETCH (MAX_SKETCH),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_klen         (klen),
        .i_jlen         (jlen),
        .i_kind         (i_in.kind),
        .i_base         (i_in.base),
        .i_last         (i_in.last),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_slot_or_best (o_out.slot_or_best),
        .o_found        (o_out.found),
        .o_hits         (o_out.hits),
        .o_query_size   (o_out.query_size),
        .o_stored_size  (o_out.stored_size)
    );

endmodule

`default_nettype wire
